// File: rtl/pmc_pkg.sv
// Shared types, geometry constants and the YCbCr palette for the tiled canvas.
// No dependencies; every module of the block imports this package.

package pmc_pkg;

  // Frame geometry
  localparam int BLOCK_COLS   = 40;
  localparam int BLOCK_ROWS   = 30;
  localparam int PIXEL_COLS   = 320;
  localparam int PIXEL_ROWS   = 240;
  localparam int TILE_PIXELS  = 8 * 8;
  localparam int TOTAL_BLOCKS = BLOCK_COLS * BLOCK_ROWS;
  localparam int DEPTH        = TOTAL_BLOCKS * TILE_PIXELS;

  // Widths of block numbers and store addresses
  localparam int BLK_W     = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
  localparam int OFFS_W    = 6;
  localparam int ADDR_W    = BLK_W + OFFS_W;
  localparam int RAW_BLK_W = $clog2(8191 * (BLOCK_COLS + 1) + 1);
  localparam int WRAP_W    = (RAW_BLK_W > BLK_W + 1) ? RAW_BLK_W : BLK_W + 1;

  // Number of component planes in a block
  localparam logic [1:0] PLANES = 2'd3;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_CLEAR
  } bk_state_t;

  // Classified command, front to back
  typedef struct packed {
    op_t               op;
    logic [WRAP_W-1:0] blk_raw;
    logic              hit;
    logic [OFFS_W-1:0] offs;
    logic [1:0]        plane;
    logic [5:0]        color;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [7:0] block_byte;
  } res_t;

  // Result queue status seen by the back end
  typedef struct packed {
    logic full;
    logic almost_full;
  } res_stat_t;

  // Palette word: {Y, Cb, Cr}
  localparam logic [23:0] PALETTE [64] = '{
    {8'd16,  8'd128, 8'd128}, {8'd38,  8'd115, 8'd165},
    {8'd60,  8'd103, 8'd203}, {8'd82,  8'd90,  8'd240},
    {8'd59,  8'd103, 8'd97},  {8'd81,  8'd91,  8'd134},
    {8'd103, 8'd78,  8'd171}, {8'd124, 8'd66,  8'd209},
    {8'd102, 8'd79,  8'd65},  {8'd124, 8'd66,  8'd103},
    {8'd145, 8'd53,  8'd140}, {8'd167, 8'd41,  8'd177},
    {8'd145, 8'd54,  8'd34},  {8'd166, 8'd41,  8'd71},
    {8'd188, 8'd29,  8'd109}, {8'd210, 8'd16,  8'd146},
    {8'd24,  8'd165, 8'd122}, {8'd46,  8'd153, 8'd159},
    {8'd68,  8'd140, 8'd197}, {8'd90,  8'd128, 8'd234},
    {8'd67,  8'd141, 8'd91},  {8'd89,  8'd128, 8'd128},
    {8'd111, 8'd115, 8'd165}, {8'd133, 8'd103, 8'd203},
    {8'd110, 8'd116, 8'd59},  {8'd132, 8'd103, 8'd97},
    {8'd154, 8'd91,  8'd134}, {8'd176, 8'd78,  8'd171},
    {8'd153, 8'd91,  8'd28},  {8'd175, 8'd79,  8'd65},
    {8'd197, 8'd66,  8'd103}, {8'd218, 8'd53,  8'd140},
    {8'd33,  8'd203, 8'd116}, {8'd55,  8'd190, 8'd153},
    {8'd76,  8'd177, 8'd191}, {8'd98,  8'd165, 8'd228},
    {8'd76,  8'd178, 8'd85},  {8'd97,  8'd165, 8'd122},
    {8'd119, 8'd153, 8'd159}, {8'd141, 8'd140, 8'd197},
    {8'd118, 8'd153, 8'd53},  {8'd140, 8'd141, 8'd91},
    {8'd162, 8'd128, 8'd128}, {8'd184, 8'd115, 8'd165},
    {8'd161, 8'd128, 8'd22},  {8'd183, 8'd116, 8'd59},
    {8'd205, 8'd103, 8'd97},  {8'd227, 8'd91,  8'd134},
    {8'd41,  8'd240, 8'd110}, {8'd63,  8'd227, 8'd147},
    {8'd85,  8'd215, 8'd185}, {8'd107, 8'd202, 8'd222},
    {8'd84,  8'd215, 8'd79},  {8'd106, 8'd203, 8'd116},
    {8'd128, 8'd190, 8'd153}, {8'd149, 8'd177, 8'd191},
    {8'd127, 8'd190, 8'd47},  {8'd149, 8'd178, 8'd85},
    {8'd170, 8'd165, 8'd122}, {8'd192, 8'd153, 8'd159},
    {8'd170, 8'd166, 8'd16},  {8'd191, 8'd153, 8'd53},
    {8'd213, 8'd141, 8'd91},  {8'd235, 8'd128, 8'd128}
  };

endpackage

// File: rtl/palette_mcu_tiled_canvas.sv
// Top level of the tiled YCbCr palette canvas: front, back and result queue.
// Depends on pmc_pkg, pmc_front, pmc_back and pmc_res_queue.
//
//   channel   handshake      payload
//   command   push / full    op, px, py, color, block_index, byte_in_block
//   result    empty / pop    luma, chroma_blue, chroma_red, block_byte
//
// Set, get and block-byte reads run at one per cycle while no clear runs and the
// result queue has room; a result passes the command queue, the registered store
// read and the result queue before it is on the result ports.
// Clear writes one pixel a cycle through the single store port, 76800 entries.
// Reset empties both queues and the sequencer; store contents are not cleared.
// full rises with four commands waiting; the back end stops issuing while the
// result queue holds three or more results.

module palette_mcu_tiled_canvas
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [15:0] px,
  input  logic [15:0] py,
  input  logic [7:0]  color,
  input  logic [11:0] block_index,
  input  logic [7:0]  byte_in_block,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  luma,
  output logic [7:0]  chroma_blue,
  output logic [7:0]  chroma_red,
  output logic [7:0]  block_byte
);

  logic      q_valid;
  cmd_t      q_cmd;
  logic      q_pop;
  res_stat_t res_stat;
  logic      res_push;
  res_t      res;
  res_t      head_res;

  pmc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .op            (op),
    .px            (px),
    .py            (py),
    .color         (color),
    .block_index   (block_index),
    .byte_in_block (byte_in_block),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  pmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .res_stat (res_stat),
    .res_push (res_push),
    .res      (res)
  );

  pmc_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .pop      (pop),
    .empty    (empty),
    .head_res (head_res),
    .stat     (res_stat)
  );

  assign luma        = head_res.luma;
  assign chroma_blue = head_res.chroma_blue;
  assign chroma_red  = head_res.chroma_red;
  assign block_byte  = head_res.block_byte;

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_stat.full)
    else $error("result pushed into a full queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command taken from an empty queue");

  a_flags_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({full, empty}))
    else $error("queue flags unknown");
`endif

endmodule

// File: rtl/pmc_front.sv
// Front end: classifies incoming operations and holds them in a short command queue.
// Depends on pmc_pkg for the command type, geometry constants and queue depth.

module pmc_front
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [15:0] px,
  input  logic [15:0] py,
  input  logic [7:0]  color,
  input  logic [11:0] block_index,
  input  logic [7:0]  byte_in_block,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t                 cmd_in;
  logic                 x_in;
  logic                 y_in;
  logic [WRAP_W-1:0]    pix_blk;
  logic                 push_ok;
  cmd_t                 cmd_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] head;
  logic [CMD_PTR_W-1:0] tail;
  logic [CMD_PTR_W:0]   count;
  logic [CMD_PTR_W:0]   count_next;

  // Locate the pixel's block before any wrap
  assign x_in    = px < 16'(PIXEL_COLS);
  assign y_in    = py < 16'(PIXEL_ROWS);
  assign pix_blk = WRAP_W'(px[15:3]) + WRAP_W'(py[15:3]) * WRAP_W'(BLOCK_COLS);

  // Classify the operation
  always_comb begin
    cmd_in.op      = op_t'(op);
    cmd_in.color   = color[5:0];
    cmd_in.blk_raw = '0;
    cmd_in.hit     = 1'b0;
    cmd_in.offs    = '0;
    cmd_in.plane   = '0;
    unique case (op_t'(op))
      OP_SET, OP_GET: begin
        cmd_in.blk_raw = pix_blk;
        cmd_in.hit     = x_in && y_in;
        cmd_in.offs    = {py[2:0], px[2:0]};
      end
      OP_CLEAR: begin
        cmd_in.hit = 1'b0;
      end
      OP_BYTE: begin
        cmd_in.blk_raw = WRAP_W'(block_index);
        cmd_in.hit     = byte_in_block[7:6] < PLANES;
        cmd_in.offs    = byte_in_block[5:0];
        cmd_in.plane   = byte_in_block[7:6];
      end
      default: begin
        cmd_in.hit = 1'b0;
      end
    endcase
  end

  assign full    = count == (CMD_PTR_W + 1)'(CMD_DEPTH);
  assign push_ok = push && !full;
  assign q_valid = count != '0;
  assign q_cmd   = cmd_q[head];

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push_ok && !q_pop) begin
      count_next = count + 1'b1;
    end else if (!push_ok && q_pop) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        tail <= tail + 1'b1;
      end
      if (q_pop) begin
        head <= head + 1'b1;
      end
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push_ok) begin
      cmd_q[tail] <= cmd_in;
    end
  end

endmodule

// File: rtl/pmc_back.sv
// Back end: block wrap, pixel store, clear sweep and result formation.
// Depends on pmc_pkg for the command and result types and the palette.

module pmc_back
  import pmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  input  res_stat_t res_stat,
  output logic      res_push,
  output res_t      res
);

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [WRAP_W-1:0] TOT      = WRAP_W'(TOTAL_BLOCKS);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [23:0]       clr_word;
  logic [23:0]       mem [DEPTH];
  logic [23:0]       rdata;
  logic [WRAP_W-1:0] blk_wrap;
  logic              addr_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic              issue_ok;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [23:0]       mem_wdata;
  logic              s2_load;
  op_t               s2_op_next;
  logic              s2_ok_next;
  logic              s2_valid;
  op_t               s2_op;
  logic              s2_ok;
  logic [1:0]        s2_plane;
  logic [7:0]        plane_byte;

  // Single wrap of the block number
  assign blk_wrap = (q_cmd.blk_raw >= TOT) ? q_cmd.blk_raw - TOT : q_cmd.blk_raw;
  assign addr_ok  = q_cmd.hit && (blk_wrap < TOT);
  assign pix_addr = {blk_wrap[BLK_W-1:0], q_cmd.offs};
  assign issue_ok = q_valid && !res_stat.almost_full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (issue_ok && q_cmd.op == OP_CLEAR) begin
          state_next = BK_CLEAR;
        end
      end
      BK_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pix_addr;
    mem_wdata  = PALETTE[q_cmd.color];
    s2_load    = 1'b0;
    s2_op_next = q_cmd.op;
    s2_ok_next = addr_ok;
    unique case (state)
      BK_RUN: begin
        q_pop   = issue_ok;
        mem_we  = issue_ok && q_cmd.op == OP_SET && addr_ok;
        s2_load = issue_ok && q_cmd.op != OP_CLEAR;
      end
      BK_CLEAR: begin
        mem_addr   = clr_cnt;
        mem_we     = 1'b1;
        mem_wdata  = clr_word;
        s2_load    = clr_cnt == CLR_LAST;
        s2_op_next = OP_CLEAR;
        s2_ok_next = 1'b0;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Hold state, sweep counter and result stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_RUN;
      clr_cnt  <= '0;
      s2_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s2_valid <= s2_load;
      if (state == BK_RUN) begin
        clr_cnt <= '0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Latch the clear color and the result stage payload
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_CLEAR) begin
      clr_word <= PALETTE[q_cmd.color];
    end
    if (s2_load) begin
      s2_op    <= s2_op_next;
      s2_ok    <= s2_ok_next;
      s2_plane <= q_cmd.plane;
    end
  end

  // Pixel store, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Pick the plane for a block-byte read
  always_comb begin
    case (s2_plane)
      2'd0:    plane_byte = rdata[23:16];
      2'd1:    plane_byte = rdata[15:8];
      default: plane_byte = rdata[7:0];
    endcase
  end

  // Form the result
  assign res_push          = s2_valid;
  assign res.luma          = (s2_op == OP_GET && s2_ok) ? rdata[23:16] : 8'd0;
  assign res.chroma_blue   = (s2_op == OP_GET && s2_ok) ? rdata[15:8]  : 8'd0;
  assign res.chroma_red    = (s2_op == OP_GET && s2_ok) ? rdata[7:0]   : 8'd0;
  assign res.block_byte    = (s2_op == OP_BYTE && s2_ok) ? plane_byte  : 8'd0;

`ifndef SYNTHESIS
  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN && q_pop && q_cmd.op == OP_CLEAR)
      |=> (state == BK_CLEAR && clr_cnt == '0))
    else $error("clear sweep did not start at entry zero");

  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR) |-> !q_pop)
    else $error("command taken during clear sweep");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR && clr_cnt == CLR_LAST) |=> (s2_valid && s2_op == OP_CLEAR))
    else $error("clear sweep ended without a result");
`endif

endmodule

// File: rtl/pmc_res_queue.sv
// Result queue between the back end and the consumer.
// Depends on pmc_pkg for the result type, status struct and depth.

module pmc_res_queue
  import pmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_push,
  input  res_t      res,
  input  logic      pop,
  output logic      empty,
  output res_t      head_res,
  output res_stat_t stat
);

  res_t                 res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] head;
  logic [RES_PTR_W-1:0] tail;
  logic [RES_PTR_W:0]   count;
  logic [RES_PTR_W:0]   count_next;
  logic                 pop_ok;

  assign empty            = count == '0;
  assign pop_ok           = pop && !empty;
  assign head_res         = res_q[head];
  assign stat.full        = count == (RES_PTR_W + 1)'(RES_DEPTH);
  assign stat.almost_full = count >= (RES_PTR_W + 1)'(RES_DEPTH - 1);

  // Track occupancy
  always_comb begin
    count_next = count;
    if (res_push && !pop_ok) begin
      count_next = count + 1'b1;
    end else if (!res_push && pop_ok) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (res_push) begin
        tail <= tail + 1'b1;
      end
      if (pop_ok) begin
        head <= head + 1'b1;
      end
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[tail] <= res;
    end
  end

endmodule

// File: bench/palette_mcu_tiled_canvas_tb.sv
// Self-checking bench for palette_mcu_tiled_canvas: random and directed pixel, clear and
// block-byte traffic, each result checked against a tile-store predictor.
// Depends on pmc_pkg (geometry, op_t) and the palette_mcu_tiled_canvas RTL.

module palette_mcu_tiled_canvas_tb;
  import pmc_pkg::*;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [7:0] blk_byte;
  } canvas_result_t;

  // Tile-store predictor and queue of readbacks still owed by the block
  class canvas_scoreboard;
    logic [23:0]    ycc [64];
    logic [23:0]    drawn [int];
    logic [23:0]    fill_word;
    canvas_result_t readback_q [$];
    int             mismatches;

    function new();
      ycc = '{
        {8'd16,8'd128,8'd128}, {8'd38,8'd115,8'd165}, {8'd60,8'd103,8'd203}, {8'd82,8'd90,8'd240},
        {8'd59,8'd103,8'd97}, {8'd81,8'd91,8'd134}, {8'd103,8'd78,8'd171}, {8'd124,8'd66,8'd209},
        {8'd102,8'd79,8'd65}, {8'd124,8'd66,8'd103}, {8'd145,8'd53,8'd140}, {8'd167,8'd41,8'd177},
        {8'd145,8'd54,8'd34}, {8'd166,8'd41,8'd71}, {8'd188,8'd29,8'd109}, {8'd210,8'd16,8'd146},
        {8'd24,8'd165,8'd122}, {8'd46,8'd153,8'd159}, {8'd68,8'd140,8'd197}, {8'd90,8'd128,8'd234},
        {8'd67,8'd141,8'd91}, {8'd89,8'd128,8'd128}, {8'd111,8'd115,8'd165}, {8'd133,8'd103,8'd203},
        {8'd110,8'd116,8'd59}, {8'd132,8'd103,8'd97}, {8'd154,8'd91,8'd134}, {8'd176,8'd78,8'd171},
        {8'd153,8'd91,8'd28}, {8'd175,8'd79,8'd65}, {8'd197,8'd66,8'd103}, {8'd218,8'd53,8'd140},
        {8'd33,8'd203,8'd116}, {8'd55,8'd190,8'd153}, {8'd76,8'd177,8'd191}, {8'd98,8'd165,8'd228},
        {8'd76,8'd178,8'd85}, {8'd97,8'd165,8'd122}, {8'd119,8'd153,8'd159}, {8'd141,8'd140,8'd197},
        {8'd118,8'd153,8'd53}, {8'd140,8'd141,8'd91}, {8'd162,8'd128,8'd128}, {8'd184,8'd115,8'd165},
        {8'd161,8'd128,8'd22}, {8'd183,8'd116,8'd59}, {8'd205,8'd103,8'd97}, {8'd227,8'd91,8'd134},
        {8'd41,8'd240,8'd110}, {8'd63,8'd227,8'd147}, {8'd85,8'd215,8'd185}, {8'd107,8'd202,8'd222},
        {8'd84,8'd215,8'd79}, {8'd106,8'd203,8'd116}, {8'd128,8'd190,8'd153}, {8'd149,8'd177,8'd191},
        {8'd127,8'd190,8'd47}, {8'd149,8'd178,8'd85}, {8'd170,8'd165,8'd122}, {8'd192,8'd153,8'd159},
        {8'd170,8'd166,8'd16}, {8'd191,8'd153,8'd53}, {8'd213,8'd141,8'd91}, {8'd235,8'd128,8'd128}
      };
      fill_word  = '0;
      mismatches = 0;
    endfunction

    // In-frame pixels always land below the block total, so no wrap is needed here
    function int pixel_pos(int x, int y);
      return (x / 8 + (y / 8) * BLOCK_COLS) * TILE_PIXELS + (y % 8) * 8 + x % 8;
    endfunction

    // Pixels not drawn since the last clear hold the clear color
    function logic [23:0] stored(int pos);
      return drawn.exists(pos) ? drawn[pos] : fill_word;
    endfunction

    // Apply one accepted command to the store and queue its readback
    function void note_command(op_t o, logic [15:0] x, logic [15:0] y, logic [7:0] c,
                               logic [11:0] bi, logic [7:0] bb);
      canvas_result_t res;
      logic [23:0]    w;
      int             blk;
      int             plane;
      bit             on_frame;
      res      = '0;
      on_frame = (x < PIXEL_COLS) && (y < PIXEL_ROWS);
      case (o)
        OP_SET: begin
          if (on_frame) drawn[pixel_pos(x, y)] = ycc[c[5:0]];
        end
        OP_GET: begin
          if (on_frame) begin
            w               = stored(pixel_pos(x, y));
            res.luma        = w[23:16];
            res.chroma_blue = w[15:8];
            res.chroma_red  = w[7:0];
          end
        end
        OP_CLEAR: begin
          drawn.delete();
          fill_word = ycc[c[5:0]];
        end
        default: begin
          // wrap the block number once; anything still past the end reads zero
          blk = bi;
          if (blk >= TOTAL_BLOCKS) blk -= TOTAL_BLOCKS;
          plane = bb / TILE_PIXELS;
          if (blk < TOTAL_BLOCKS && plane < 3) begin
            w = stored(blk * TILE_PIXELS + bb % TILE_PIXELS);
            case (plane)
              0:       res.blk_byte = w[23:16];
              1:       res.blk_byte = w[15:8];
              default: res.blk_byte = w[7:0];
            endcase
          end
        end
      endcase
      readback_q.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one result transfer against the oldest readback
    task check_result(canvas_result_t got);
      canvas_result_t want;
      if (readback_q.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
        return;
      end
      want = readback_q.pop_front();
      if (got.luma !== want.luma)
        report($sformatf("luma got %0d want %0d", got.luma, want.luma));
      if (got.chroma_blue !== want.chroma_blue)
        report($sformatf("chroma_blue got %0d want %0d", got.chroma_blue, want.chroma_blue));
      if (got.chroma_red !== want.chroma_red)
        report($sformatf("chroma_red got %0d want %0d", got.chroma_red, want.chroma_red));
      if (got.blk_byte !== want.blk_byte)
        report($sformatf("block_byte got %0d want %0d", got.blk_byte, want.blk_byte));
    endtask
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        push          = 1'b0;
  logic        pop           = 1'b0;
  op_t         cmd_op        = OP_SET;
  logic [15:0] px            = '0;
  logic [15:0] py            = '0;
  logic [7:0]  color         = '0;
  logic [11:0] block_index   = '0;
  logic [7:0]  byte_in_block = '0;
  logic        full;
  logic        empty;
  logic [7:0]  luma;
  logic [7:0]  chroma_blue;
  logic [7:0]  chroma_red;
  logic [7:0]  block_byte;

  canvas_scoreboard sb;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               clears_left;
  logic [31:0]      recent_spots [$];

  palette_mcu_tiled_canvas DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .op            (cmd_op),
    .px            (px),
    .py            (py),
    .color         (color),
    .block_index   (block_index),
    .byte_in_block (byte_in_block),
    .empty         (empty),
    .pop           (pop),
    .luma          (luma),
    .chroma_blue   (chroma_blue),
    .chroma_red    (chroma_red),
    .block_byte    (block_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe transfers on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full)
        sb.note_command(cmd_op, px, py, color, block_index, byte_in_block);
      if (pop && !empty)
        sb.check_result(canvas_result_t'({luma, chroma_blue, chroma_red, block_byte}));
    end
  end

  // Hold one command until its transfer, with random idle cycles ahead of it
  task automatic send_command(input op_t o, input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] c, input logic [11:0] bi,
                              input logic [7:0] bb);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    cmd_op        <= o;
    px            <= x;
    py            <= y;
    color         <= c;
    block_index   <= bi;
    byte_in_block <= bb;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [15:0] near_limit(int n);
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'(n - 1);
      2:       return 16'(n);
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly in-frame draws and readbacks of recently drawn pixels, some noise
  task automatic random_command();
    op_t         o;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  c;
    logic [7:0]  bb;
    logic [11:0] bi;
    logic [31:0] spot;
    int          pick;
    int          mode;
    x    = 16'($urandom);
    y    = 16'($urandom);
    c    = 8'($urandom);
    bi   = 12'($urandom);
    bb   = 8'($urandom);
    pick = $urandom_range(999);
    mode = $urandom_range(99);
    if (pick < 3 && clears_left > 0) begin
      o = OP_CLEAR;
      clears_left--;
    end else if (pick < 400) begin
      o = OP_SET;
    end else if (pick < 700) begin
      o = OP_GET;
    end else begin
      o = OP_BYTE;
    end
    if (o == OP_SET || o == OP_GET) begin
      if (o == OP_GET && mode < 45 && recent_spots.size() > 0) begin
        spot = recent_spots[$urandom_range(recent_spots.size() - 1)];
        x    = spot[31:16];
        y    = spot[15:0];
      end else if (mode < 80) begin
        x = 16'($urandom_range(PIXEL_COLS - 1));
        y = 16'($urandom_range(PIXEL_ROWS - 1));
      end else if (mode < 90) begin
        x = near_limit(PIXEL_COLS);
        y = near_limit(PIXEL_ROWS);
      end
      if (o == OP_SET && x < PIXEL_COLS && y < PIXEL_ROWS) begin
        recent_spots.push_back({x, y});
        if (recent_spots.size() > 16) void'(recent_spots.pop_front());
      end
    end else if (o == OP_BYTE) begin
      if (mode < 60 && recent_spots.size() > 0) begin
        // aim at a drawn pixel, sometimes through the wrapped index
        spot = recent_spots[$urandom_range(recent_spots.size() - 1)];
        bi   = 12'(spot[31:16] / 8 + (spot[15:0] / 8) * BLOCK_COLS);
        if ($urandom_range(3) == 0) bi = bi + 12'(TOTAL_BLOCKS);
        bb   = 8'($urandom_range(2) * TILE_PIXELS + spot[2:0] * 8 + spot[18:16]);
      end else if (mode < 85) begin
        bb = 8'($urandom_range(3 * TILE_PIXELS - 1));
      end
    end
    send_command(o, x, y, c, bi, bb);
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 36;
    recv_idle_pct = 88;
    clears_left   = 4;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: clear first so nothing unwritten is read; color high bits ignored
    send_command(OP_CLEAR, 16'd0, 16'd0, 8'hFF, 12'd0, 8'd0);
    send_command(OP_GET, 16'd0, 16'd0, 8'h00, 12'hFFF, 8'hFF);
    send_command(OP_SET, 16'd0, 16'd0, 8'h00, 12'd0, 8'd0);
    send_command(OP_GET, 16'd0, 16'd0, 8'h00, 12'd0, 8'd0);
    send_command(OP_SET, 16'd319, 16'd239, 8'h03, 12'd0, 8'd0);
    send_command(OP_GET, 16'd319, 16'd239, 8'h00, 12'd0, 8'd0);
    // pixels outside the frame
    send_command(OP_SET, 16'd320, 16'd0, 8'h05, 12'd0, 8'd0);
    send_command(OP_SET, 16'hFFFF, 16'hFFFF, 8'h05, 12'd0, 8'd0);
    send_command(OP_GET, 16'd320, 16'd0, 8'h00, 12'd0, 8'd0);
    send_command(OP_GET, 16'd0, 16'd240, 8'h00, 12'd0, 8'd0);
    send_command(OP_GET, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF, 8'hFF);
    // block bytes of pixel (7, 9): block 40, offset 15, in each plane
    send_command(OP_SET, 16'd7, 16'd9, 8'hC5, 12'd0, 8'd0);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd40, 8'd15);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd40, 8'd79);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd40, 8'd143);
    // wrapped index, last block, and indexes past the single wrap
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd1240, 8'd79);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd2399, 8'd191);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd2400, 8'd0);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'hFFF, 8'd15);
    // byte offsets past the red plane
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd40, 8'd192);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd0, 8'd255);
    send_command(OP_CLEAR, 16'hFFFF, 16'hFFFF, 8'h2A, 12'hFFF, 8'hFF);
    send_command(OP_GET, 16'd319, 16'd239, 8'h00, 12'd0, 8'd0);
    send_command(OP_BYTE, 16'd0, 16'd0, 8'd0, 12'd40, 8'd15);

    // Random traffic in three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (330) random_command();
    end
    push <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (sb.readback_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("palette_mcu_tiled_canvas_tb passed");
    end else begin
      $display("palette_mcu_tiled_canvas_tb failed");
    end
    $finish;
  end

  // Watchdog: six full clears plus traffic fit well inside this
  initial begin
    #80000000;
    $display("palette_mcu_tiled_canvas_tb failed");
    $finish;
  end

endmodule
